[rtl/three_stacks_shared_node_pool_unit_defines.svh]
// Assertion helpers for the node pool unit.
`ifndef THREE_STACKS_SHARED_NODE_POOL_UNIT_DEFINES_SVH
`define THREE_STACKS_SHARED_NODE_POOL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define TSNP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define TSNP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSNP_ASSERT(lbl, prop, msg)
`define TSNP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/tsnp_pkg.sv]
`default_nettype none
package tsnp_pkg;

  localparam int POOL_ENTRIES  = 64;
  localparam int STACK_COUNT   = 3;
  localparam int FIRST_STORAGE = 3;
  localparam int NODE_W        = $clog2(POOL_ENTRIES);
  localparam int FILL_W        = $clog2(POOL_ENTRIES + 1);
  localparam int DATA_W        = 32;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic {
    PH_IDLE,
    PH_EXEC
  } phase_t;

endpackage
`default_nettype wire

[rtl/three_stacks_shared_node_pool_unit.sv]
// Three LIFO stacks sharing one pool of linked nodes.
// Input channel (s_*): one transfer is one operation. s_tuser carries the
// opcode (push/pop) and the stack select, s_tdata the word to push.
// Output channel (m_*): exactly one result transfer per operation, in order:
// popped word on m_tdata, status / stack-empty mask / pool-full on m_tuser.
//
// Sequence: the accept cycle issues the read of the link and value
// memories at the addressed node; the exec phase then sees the read data,
// writes the link/value back and updates tops and free head. A new operation
// is not accepted until that write-back is done. The result is loaded into
// the output register at the same edge as the write-back.
//
// The output register decouples the sides: a new operation is accepted while
// a result still waits. If the receiver stalls, the write-back cycle holds
// until the output register can be loaded, and s_tready stays low.
//
// Reset (rst, synchronous): all stacks empty, free head at the first storage
// node. No clearing pass: a fill count marks the nodes never used, whose
// link reads as its reset value (next node, last node links null).
`default_nettype none
`include "three_stacks_shared_node_pool_unit_defines.svh"

module three_stacks_shared_node_pool_unit
  import tsnp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] push_value
  input  wire logic [7:0]  s_tuser,   // [0] opcode, [2:1] stack_sel, [7:3] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] pop_value
  output logic [7:0]       m_tuser    // [1:0] status, [4:2] empty_mask,
                                      // [5] pool_full, [7:6] zero
);

  // Memories: link and stored word per node.
  node_t              link_mem  [POOL_ENTRIES];
  logic [DATA_W-1:0]  value_mem [POOL_ENTRIES];
  node_t              link_q;
  logic [DATA_W-1:0]  value_q;

  // Control state.
  phase_t             phase, phase_next;
  node_t              stack_top [STACK_COUNT];
  node_t              free_head;
  logic [FILL_W-1:0]  fill;        // nodes at or above this were never written

  // Operation captured at accept.
  logic               op_r;
  logic [1:0]         sel_r;
  logic [DATA_W-1:0]  val_r;
  node_t              node_r;
  logic               refused_r;

  logic               accept;
  logic               exec_fire;

  // Decode at accept.
  logic               in_op;
  logic [1:0]         in_sel;
  node_t              in_top;
  logic               in_sel_ok;
  node_t              in_node;
  logic               in_refused;

  assign in_op  = s_tuser[0];
  assign in_sel = s_tuser[2:1];

  always_comb begin
    in_top    = '0;
    in_sel_ok = 1'b0;
    for (int k = 0; k < STACK_COUNT; k++) begin
      if (in_sel == 2'(k)) begin
        in_top    = stack_top[k];
        in_sel_ok = 1'b1;
      end
    end
    in_node    = (in_op == OP_PUSH) ? free_head : in_top;
    in_refused = !in_sel_ok || (in_node == '0);
  end

  // Phase sequencing.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: if (accept)    phase_next = PH_EXEC;
      PH_EXEC: if (exec_fire) phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (phase == PH_IDLE);
    exec_fire = (phase == PH_EXEC) && (!m_tvalid || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_op;
      sel_r     <= in_sel;
      val_r     <= s_tdata;
      node_r    <= in_node;
      refused_r <= in_refused;
    end
  end

  // Memory read port: addressed at accept, data valid in the exec cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      link_q  <= link_mem[in_node];
      value_q <= value_mem[in_node];
    end
  end

  // Effective link: untouched nodes still hold the initial chain.
  logic [FILL_W-1:0]  node_inc;
  logic               node_fresh;
  node_t              link_eff;

  always_comb begin
    node_inc   = FILL_W'(node_r) + FILL_W'(1);
    node_fresh = (FILL_W'(node_r) >= fill);
    if (node_fresh) begin
      link_eff = (node_inc == FILL_W'(POOL_ENTRIES)) ? '0 : node_inc[NODE_W-1:0];
    end else begin
      link_eff = link_q;
    end
  end

  // Write-back values.
  logic               do_push;
  logic               do_pop;
  node_t              top_r;
  node_t              top_next [STACK_COUNT];
  node_t              free_next;
  logic [STACK_COUNT-1:0] empty_next;

  always_comb begin
    do_push = exec_fire && !refused_r && (op_r == OP_PUSH);
    do_pop  = exec_fire && !refused_r && (op_r == OP_POP);
    top_r   = '0;
    for (int k = 0; k < STACK_COUNT; k++) begin
      if (sel_r == 2'(k)) top_r = stack_top[k];
    end
    free_next = free_head;
    if (do_push) free_next = link_eff;
    if (do_pop)  free_next = node_r;
    for (int k = 0; k < STACK_COUNT; k++) begin
      top_next[k] = stack_top[k];
      if (sel_r == 2'(k)) begin
        if (do_push) top_next[k] = node_r;
        if (do_pop)  top_next[k] = link_eff;
      end
      empty_next[k] = (top_next[k] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      link_mem[node_r]  <= top_r;
      value_mem[node_r] <= val_r;
    end else if (do_pop) begin
      link_mem[node_r]  <= free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STACK_COUNT; k++) stack_top[k] <= '0;
      free_head <= node_t'(FIRST_STORAGE);
      fill      <= FILL_W'(FIRST_STORAGE);
    end else begin
      for (int k = 0; k < STACK_COUNT; k++) stack_top[k] <= top_next[k];
      free_head <= free_next;
      if (do_push && node_fresh) fill <= node_inc;
    end
  end

  // Output register.
  logic [1:0] status_w;

  always_comb begin
    if (!refused_r)            status_w = STATUS_OK;
    else if (op_r == OP_PUSH)  status_w = STATUS_FULL;
    else                       status_w = STATUS_EMPTY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      m_tdata <= do_pop ? value_q : '0;
      m_tuser <= {2'b00, (free_next == '0), empty_next, status_w};
    end
  end

  // Checks.
  `TSNP_ASSERT(a_one_op_in_flight, accept |=> !s_tready, "second transfer accepted mid-op")
  `TSNP_ASSERT(a_exec_loads_out, exec_fire |=> m_tvalid, "result not presented after exec")
  `TSNP_ASSERT(a_refused_zero, (m_tvalid && m_tuser[1:0] != STATUS_OK) |-> (m_tdata == '0),
               "refused op returned nonzero word")
  `TSNP_ASSERT(a_fill_range, fill <= FILL_W'(POOL_ENTRIES), "fill count overrun")
  `TSNP_ASSERT(a_free_head_storage,
               (free_head == '0) || (FILL_W'(free_head) >= FILL_W'(FIRST_STORAGE)),
               "free head points at a reserved node")

endmodule
`default_nettype wire

[bench/three_stacks_shared_node_pool_unit_tb.sv]
`timescale 1ns / 1ps

module three_stacks_shared_node_pool_unit_tb
  import tsnp_pkg::*;
;

  localparam int RANDOM_OPS   = 1530;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int PRINT_CAP    = 50;

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    logic [1:0]        status;
    logic [2:0]        empty_mask;
    logic              pool_full;
  } pool_outcome_t;

  typedef enum int {
    MODE_FILL,
    MODE_CHURN,
    MODE_DRAIN
  } traffic_mode_t;

  // Shadow copy of the three stacks and the free list, plus the queue of
  // results still owed by the block.
  class stack_pool_tracker;
    node_t             stack_top [STACK_COUNT];
    node_t             node_link [POOL_ENTRIES];
    logic [DATA_W-1:0] node_value [POOL_ENTRIES];
    node_t             free_head;
    pool_outcome_t     pending_outcomes [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       pushes_stored;
    int unsigned       pushes_refused;
    int unsigned       pops_served;
    int unsigned       pops_refused;
    int unsigned       nodes_used;
    int unsigned       peak_nodes;

    function new();
      for (int k = 0; k < STACK_COUNT; k++)
        stack_top[k] = '0;
      for (int k = 0; k < POOL_ENTRIES; k++) begin
        node_link[k]  = (k + 1 < POOL_ENTRIES) ? node_t'(k + 1) : '0;
        node_value[k] = '0;
      end
      free_head = node_t'(FIRST_STORAGE);
    endfunction

    // Accepted operation: update the shadow pool and queue its result.
    function void apply_stack_op(logic op, logic [1:0] sel, logic [DATA_W-1:0] word);
      pool_outcome_t res;
      node_t         n;
      res = '0;
      if (op == OP_PUSH) begin
        if (sel >= STACK_COUNT || free_head == '0) begin
          res.status = STATUS_FULL;
          pushes_refused++;
        end else begin
          n              = free_head;
          free_head      = node_link[n];
          node_value[n]  = word;
          node_link[n]   = stack_top[sel];
          stack_top[sel] = n;
          pushes_stored++;
          nodes_used++;
          if (nodes_used > peak_nodes)
            peak_nodes = nodes_used;
        end
      end else begin
        if (sel >= STACK_COUNT || stack_top[sel] == '0) begin
          res.status = STATUS_EMPTY;
          pops_refused++;
        end else begin
          n              = stack_top[sel];
          stack_top[sel] = node_link[n];
          node_link[n]   = free_head;
          free_head      = n;
          res.pop_value  = node_value[n];
          res.status     = STATUS_OK;
          pops_served++;
          nodes_used--;
        end
      end
      for (int k = 0; k < STACK_COUNT; k++)
        res.empty_mask[k] = (stack_top[k] == '0);
      res.pool_full = (free_head == '0);
      pending_outcomes.push_back(res);
    endfunction

    task flag_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("%0t mismatch on result %0d: %s got 0x%08h want 0x%08h",
                 $realtime, checked, what, got, want);
    endtask

    task check_outcome(logic [31:0] data, logic [7:0] user);
      pool_outcome_t want;
      checked++;
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("result with nothing outstanding", {24'd0, user}, '0);
        return;
      end
      want = pending_outcomes.pop_front();
      if (data !== want.pop_value)
        flag_mismatch("pop_value", data, want.pop_value);
      if (user[1:0] !== want.status)
        flag_mismatch("status", {30'd0, user[1:0]}, {30'd0, want.status});
      if (user[4:2] !== want.empty_mask)
        flag_mismatch("empty_mask", {29'd0, user[4:2]}, {29'd0, want.empty_mask});
      if (user[5] !== want.pool_full)
        flag_mismatch("pool_full", {31'd0, user[5]}, {31'd0, want.pool_full});
    endtask

    task flush_leftovers();
      while (pending_outcomes.size() != 0) begin
        void'(pending_outcomes.pop_front());
        flag_mismatch("expected result never arrived", '0, '0);
      end
    endtask
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] push_value
  logic [7:0]  s_tuser  = '0;   // [0] opcode, [2:1] stack_sel, [7:3] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [31:0] pop_value
  logic [7:0]  m_tuser;         // [1:0] status, [4:2] empty_mask, [5] pool_full

  stack_pool_tracker board;

  bit          no_idle      = 1'b0;   // both sides busy every cycle
  bit          hold_request = 1'b0;   // asks the receiver for a long stall
  int unsigned hold_left    = 0;

  three_stacks_shared_node_pool_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", board.pending_outcomes.size());
    $display("[three_stacks_shared_node_pool_unit] ERROR");
    $finish;
  end

  // Receiver: random back-pressure, a quiet window, and one long hold-off
  // counted here so the block backs up into its input.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 37);
    end
  end

  // Results are sampled on the rising edge; TB inputs only move on the falling one.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_outcome(m_tdata, m_tuser);
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly real stacks; a few hits on the nonexistent fourth select.
  function automatic logic [1:0] pick_sel();
    if ($urandom_range(0, 99) < 6)
      return 2'd3;
    return 2'($urandom_range(0, 2));
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_op(input logic op, input logic [1:0] sel, input logic [31:0] word);
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < 37)
      gap = $urandom_range(1, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= {5'd0, sel, op};
    do @(posedge clk); while (!s_tready);
    board.apply_stack_op(op, sel, word);
    @(negedge clk);
  endtask

  initial begin : op_driver
    traffic_mode_t mode;
    int unsigned   sent;
    int unsigned   seg_len;
    int unsigned   push_pct;
    int unsigned   waited;
    logic          op;

    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty pops, the missing fourth stack, extreme words, LIFO order.
    send_op(OP_POP,  2'd0, 32'h0000_0000);
    send_op(OP_POP,  2'd1, 32'hFFFF_FFFF);
    send_op(OP_POP,  2'd2, 32'h0000_0000);
    send_op(OP_POP,  2'd3, 32'h0000_0000);
    send_op(OP_PUSH, 2'd3, 32'hFFFF_FFFF);
    send_op(OP_PUSH, 2'd0, 32'h7FFF_FFFF);
    send_op(OP_PUSH, 2'd0, 32'h8000_0000);
    send_op(OP_PUSH, 2'd1, 32'h0000_0000);
    send_op(OP_PUSH, 2'd2, 32'hFFFF_FFFF);
    send_op(OP_PUSH, 2'd2, 32'h1234_5678);
    send_op(OP_POP,  2'd3, 32'hDEAD_BEEF);
    send_op(OP_POP,  2'd0, 32'h0000_0000);
    send_op(OP_POP,  2'd0, 32'h0000_0000);
    send_op(OP_POP,  2'd0, 32'h0000_0000);
    send_op(OP_POP,  2'd1, 32'hA5A5_A5A5);
    send_op(OP_POP,  2'd2, 32'h0000_0000);
    send_op(OP_PUSH, 2'd1, 32'hA5A5_A5A5);
    send_op(OP_POP,  2'd2, 32'h0000_0000);
    send_op(OP_POP,  2'd2, 32'h0000_0000);
    send_op(OP_PUSH, 2'd1, 32'h5A5A_5A5A);
    send_op(OP_POP,  2'd1, 32'hFFFF_FFFF);
    send_op(OP_POP,  2'd1, 32'h0000_0000);

    // Random: fill past full, churn near the top, drain to empty, repeat.
    mode = MODE_FILL;
    sent = 0;
    while (sent < RANDOM_OPS) begin
      seg_len  = $urandom_range(90, 140);
      push_pct = (mode == MODE_FILL) ? 88 : (mode == MODE_DRAIN) ? 12 : 50;
      for (int i = 0; i < seg_len && sent < RANDOM_OPS; i++) begin
        no_idle = (sent >= 500 && sent < 800);
        if (sent == 1000)
          hold_request = 1'b1;
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        send_op(op, pick_sel(), pick_word());
        sent++;
      end
      case (mode)
        MODE_FILL:  mode = MODE_CHURN;
        MODE_CHURN: mode = MODE_DRAIN;
        default:    mode = MODE_FILL;
      endcase
    end
    no_idle  = 1'b0;
    s_tvalid <= 1'b0;

    waited = 0;
    while (board.pending_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    board.flush_leftovers();

    $display("ran %0d operations: %0d pushes stored, %0d refused; %0d pops served, %0d empty",
             board.pushes_stored + board.pushes_refused + board.pops_served
               + board.pops_refused,
             board.pushes_stored, board.pushes_refused, board.pops_served,
             board.pops_refused);
    $display("peak pool use %0d of %0d storage nodes; %0d results checked, %0d mismatches",
             board.peak_nodes, POOL_ENTRIES - FIRST_STORAGE, board.checked,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("[three_stacks_shared_node_pool_unit] OK");
    end else begin
      $display("[three_stacks_shared_node_pool_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/tsnp_pkg.sv
rtl/three_stacks_shared_node_pool_unit.sv
bench/three_stacks_shared_node_pool_unit_tb.sv
